@@ rtl/swepc_pkg.sv @@
`timescale 1ns / 1ps

package swepc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned POS_FIELD_W = 10;
  localparam int unsigned PAIR_W      = 19;

  // Default sizes of the sequence store and the value id range
  localparam int unsigned DEF_POSITIONS = 1024;
  localparam int unsigned DEF_VALUE_IDS = 1024;

  // Fixed-point shift of the reciprocal used to reduce load values
  localparam int unsigned RECIP_SHIFT = 20;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_QUERY_BAD = 2'd1,
    STAT_LOAD_BUSY = 2'd2
  } status_e;

  typedef struct packed {
    action_e                action;
    logic [POS_FIELD_W-1:0] load_position;
    logic [POS_FIELD_W-1:0] load_value;
    logic [POS_FIELD_W-1:0] left_index;
    logic [POS_FIELD_W-1:0] right_index;
  } swepc_in_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_count;
    status_e           status;
  } swepc_out_t;

  // One element move of the window edges
  typedef enum logic [1:0] {
    MV_GROW_LEFT,
    MV_GROW_RIGHT,
    MV_SHRINK_RIGHT,
    MV_SHRINK_LEFT
  } move_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD_DIV,
    ST_LOAD_WR,
    ST_MOVE,
    ST_CNT_RD,
    ST_CNT_WR
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    restart;
    logic    step_go;
    move_e   step_kind;
    logic    cnt_rd;
    logic    cnt_wr;
    logic    load_div;
    logic    load_wr;
    logic    clr_wr;
    logic    finish;
    status_e status;
  } swepc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_query;
    logic load_oob;
    logic load_in_win;
    logic query_bad;
    logic grow_left;
    logic grow_right;
    logic shrink_right;
    logic shrink_left;
    logic clr_last;
  } swepc_stat_t;

endpackage

@@ rtl/swepc_datapath.sv @@
`timescale 1ns / 1ps

module swepc_datapath import swepc_pkg::*; #(
  parameter int unsigned POSITIONS = DEF_POSITIONS,
  parameter int unsigned VALUE_IDS = DEF_VALUE_IDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  swepc_in_t   req_i,
  input  swepc_cmd_t  cmd_i,
  output swepc_stat_t stat_o,
  output logic        done_o,
  output swepc_out_t  result_o
);

  localparam int unsigned PW  = $clog2(POSITIONS);
  localparam int unsigned EW  = $clog2(POSITIONS + 1);
  localparam int unsigned CW  = (EW > POS_FIELD_W + 1) ? EW : POS_FIELD_W + 1;
  localparam int unsigned IW  = $clog2(VALUE_IDS);
  localparam int unsigned NW  = $clog2(POSITIONS + 1);
  localparam int unsigned RW  = (IW + 2 > POS_FIELD_W + 1) ? IW + 2 : POS_FIELD_W + 1;
  localparam int unsigned PRW = POS_FIELD_W + RECIP_SHIFT;
  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / VALUE_IDS;

  swepc_in_t              req_q;
  logic [EW-1:0]          ws_q, we_q;
  logic [PAIR_W-1:0]      total_q;
  logic [IW-1:0]          clr_q;
  logic [IW-1:0]          val_q;
  logic                   add_q;
  logic [NW-1:0]          cnt_q;
  logic [POS_FIELD_W-1:0] quo_q;
  logic                   done_q;
  swepc_out_t             result_q;

  logic [IW-1:0] store_mem [POSITIONS];
  logic [NW-1:0] occ_mem   [VALUE_IDS];

  logic [CW-1:0]  pos_c, left_c, right_c, right_sat, end_c, ws_c, we_c;
  logic           win_empty;
  logic [EW-1:0]  addr_e;
  logic [PW-1:0]  step_addr;
  logic [PRW-1:0] quo_prod;
  logic [RW-1:0]  qd, rem_raw, rem_fin;
  logic [NW-1:0]  cnt_dec;

  // Extend positions and edges to one compare width
  assign pos_c   = CW'(req_q.load_position);
  assign left_c  = CW'(req_q.left_index);
  assign right_c = CW'(req_q.right_index);
  assign ws_c    = CW'(ws_q);
  assign we_c    = CW'(we_q);

  // Saturate the right edge at the last stored position
  assign right_sat = (right_c > CW'(POSITIONS - 1)) ? CW'(POSITIONS - 1) : right_c;
  assign end_c     = right_sat + CW'(1);
  assign win_empty = (we_q <= ws_q);

  always_comb begin
    stat_o.is_query     = (req_q.action == ACT_QUERY);
    stat_o.load_oob     = (pos_c >= CW'(POSITIONS));
    stat_o.load_in_win  = (pos_c >= ws_c) && (pos_c < we_c);
    stat_o.query_bad    = (left_c > right_sat);
    stat_o.grow_left    = (ws_c > left_c);
    stat_o.grow_right   = (we_c < end_c);
    stat_o.shrink_right = (we_c > end_c);
    stat_o.shrink_left  = (ws_c < left_c);
    stat_o.clr_last     = (clr_q == IW'(VALUE_IDS - 1));
  end

  // Hold the item for the whole of its work
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Position touched by one element move
  always_comb begin
    case (cmd_i.step_kind)
      MV_GROW_LEFT:    addr_e = ws_q - EW'(1);
      MV_GROW_RIGHT:   addr_e = we_q;
      MV_SHRINK_RIGHT: addr_e = we_q - EW'(1);
      MV_SHRINK_LEFT:  addr_e = ws_q;
      default:         addr_e = ws_q;
    endcase
  end
  assign step_addr = addr_e[PW-1:0];

  // Advance the window edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      we_q <= '0;
    end else if (cmd_i.restart && win_empty) begin
      ws_q <= EW'(left_c);
      we_q <= EW'(left_c);
    end else if (cmd_i.step_go) begin
      case (cmd_i.step_kind)
        MV_GROW_LEFT:    ws_q <= ws_q - EW'(1);
        MV_GROW_RIGHT:   we_q <= we_q + EW'(1);
        MV_SHRINK_RIGHT: we_q <= we_q - EW'(1);
        MV_SHRINK_LEFT:  ws_q <= ws_q + EW'(1);
        default:         ws_q <= ws_q;
      endcase
    end
  end

  // Reduce the load value modulo the id range: reciprocal estimate, then one correction
  assign quo_prod = PRW'(req_q.load_value) * PRW'(RECIP);
  assign qd       = RW'(quo_q) * RW'(VALUE_IDS);
  assign rem_raw  = RW'(req_q.load_value) - qd;
  assign rem_fin  = (rem_raw >= RW'(VALUE_IDS)) ? rem_raw - RW'(VALUE_IDS) : rem_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      quo_q <= quo_prod[PRW-1:RECIP_SHIFT];
    end
  end

  // Value store: write on load, read the moved element
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      store_mem[pos_c[PW-1:0]] <= rem_fin[IW-1:0];
    end
    if (cmd_i.step_go) begin
      val_q <= store_mem[step_addr];
      add_q <= (cmd_i.step_kind == MV_GROW_LEFT) || (cmd_i.step_kind == MV_GROW_RIGHT);
    end
  end

  // Occupancy histogram: clear sweep or read-modify-write of one count
  assign cnt_dec = cnt_q - NW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      occ_mem[clr_q] <= '0;
    end else if (cmd_i.cnt_wr && (add_q || (cnt_q != '0))) begin
      occ_mem[val_q] <= add_q ? cnt_q + NW'(1) : cnt_dec;
    end
    if (cmd_i.cnt_rd) begin
      cnt_q <= occ_mem[val_q];
    end
  end

  // Clear sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + IW'(1);
    end
  end

  // Running pair total, kept modulo the result width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.cnt_wr) begin
      if (add_q) begin
        total_q <= total_q + PAIR_W'(cnt_q);
      end else if (cnt_q != '0) begin
        total_q <= total_q - PAIR_W'(cnt_dec);
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q.pair_count <= total_q;
      result_q.status     <= cmd_i.status;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/swepc_ctrl.sv @@
`timescale 1ns / 1ps

module swepc_ctrl import swepc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  swepc_stat_t stat_i,
  output swepc_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        any_move;

  assign any_move = stat_i.grow_left || stat_i.grow_right ||
                    stat_i.shrink_right || stat_i.shrink_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!stat_i.is_query) begin
          if (stat_i.load_oob || stat_i.load_in_win) state_d = ST_IDLE;
          else                                       state_d = ST_LOAD_DIV;
        end else if (stat_i.query_bad) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MOVE;
        end
      end
      ST_LOAD_DIV: state_d = ST_LOAD_WR;
      ST_LOAD_WR:  state_d = ST_IDLE;
      ST_MOVE: begin
        state_d = any_move ? ST_CNT_RD : ST_IDLE;
      end
      ST_CNT_RD: state_d = ST_CNT_WR;
      ST_CNT_WR: state_d = ST_MOVE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.status    = STAT_OK;
    cmd_o.step_kind = MV_GROW_LEFT;
    busy = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.capture = start;
      end
      ST_DISPATCH: begin
        if (!stat_i.is_query) begin
          if (stat_i.load_oob) begin
            cmd_o.finish = 1'b1;
          end else if (stat_i.load_in_win) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = STAT_LOAD_BUSY;
          end
        end else if (stat_i.query_bad) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STAT_QUERY_BAD;
        end else begin
          cmd_o.restart = 1'b1;
        end
      end
      ST_LOAD_DIV: begin
        cmd_o.load_div = 1'b1;
      end
      ST_LOAD_WR: begin
        cmd_o.load_wr = 1'b1;
        cmd_o.finish  = 1'b1;
      end
      ST_MOVE: begin
        // grow first, then shrink
        if (any_move) begin
          cmd_o.step_go = 1'b1;
          if (stat_i.grow_left)         cmd_o.step_kind = MV_GROW_LEFT;
          else if (stat_i.grow_right)   cmd_o.step_kind = MV_GROW_RIGHT;
          else if (stat_i.shrink_right) cmd_o.step_kind = MV_SHRINK_RIGHT;
          else                          cmd_o.step_kind = MV_SHRINK_LEFT;
        end else begin
          cmd_o.finish = 1'b1;
        end
      end
      ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
      end
      ST_CNT_WR: begin
        cmd_o.cnt_wr = 1'b1;
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/sliding_window_equal_pair_counter.sv @@
`timescale 1ns / 1ps

// Channel   Ports                     Transfer
// input     req_i, start, busy        start high and busy low at a rising edge
// result    result_o, done_o          done_o high for one cycle, taken at its end
//
// After reset the occupancy histogram is cleared, one entry a cycle, each value id once;
// busy stays high meanwhile. A stored load runs the dispatch, divide and write states before
// its strobe, a flagged item or an ignored load strobes from dispatch, and a query runs
// dispatch, then for each element the window edges move a store read, a histogram read
// and a histogram write on one port, then a last move state that strobes.
// One item is in work at a time; the next transfer can happen in the strobe cycle.
// The receiver cannot stall, so nothing is held back on the result side.

module sliding_window_equal_pair_counter import swepc_pkg::*; #(
  parameter int unsigned POSITIONS = DEF_POSITIONS,
  parameter int unsigned VALUE_IDS = DEF_VALUE_IDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  swepc_in_t  req_i,
  output logic       done_o,
  output swepc_out_t result_o
);

  swepc_cmd_t  cmd;
  swepc_stat_t stat;

  swepc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  swepc_datapath #(
    .POSITIONS (POSITIONS),
    .VALUE_IDS (VALUE_IDS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import swepc_pkg::*;

  localparam int unsigned NPOS         = DEF_POSITIONS;
  localparam int unsigned NIDS         = DEF_VALUE_IDS;
  localparam int unsigned RANDOM_ITEMS = 40;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  swepc_in_t  req_i;
  logic       done_o;
  swepc_out_t result_o;

  sliding_window_equal_pair_counter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the sequence, the histogram and the window
  logic [POS_FIELD_W-1:0] seq_ids [NPOS];
  logic [10:0]            id_hist [NIDS];
  logic [10:0]            win_lo;
  logic [10:0]            win_hi;
  logic [19:0]            pair_sum;

  swepc_out_t  pending_counts [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned n_loads;
  int unsigned n_load_refused;
  int unsigned n_queries;
  int unsigned n_query_bad;
  int unsigned peak_pairs;
  bit          no_idle;

  function automatic void clear_window_model();
    for (int i = 0; i < NIDS; i++) id_hist[i] = '0;
    for (int i = 0; i < NPOS; i++) seq_ids[i] = '0;
    win_lo   = '0;
    win_hi   = '0;
    pair_sum = '0;
  endfunction

  function automatic void hist_add(input logic [10:0] pos);
    logic [POS_FIELD_W-1:0] id;
    id = seq_ids[pos[POS_FIELD_W-1:0]];
    pair_sum = pair_sum + 20'(id_hist[id]);
    id_hist[id] = id_hist[id] + 11'd1;
  endfunction

  function automatic void hist_drop(input logic [10:0] pos);
    logic [POS_FIELD_W-1:0] id;
    id = seq_ids[pos[POS_FIELD_W-1:0]];
    if (id_hist[id] != '0) begin
      id_hist[id] = id_hist[id] - 11'd1;
      pair_sum = pair_sum - 20'(id_hist[id]);
    end
  endfunction

  // Apply one item to the shadow state and return the result it must produce
  function automatic swepc_out_t model_pair_count(input swepc_in_t req);
    swepc_out_t  rsp;
    logic [10:0] lft;
    logic [10:0] nxt_end;
    rsp.status = STAT_OK;
    if (req.action == ACT_LOAD) begin
      if (11'(req.load_position) >= win_lo && 11'(req.load_position) < win_hi) begin
        rsp.status = STAT_LOAD_BUSY;
      end else begin
        seq_ids[req.load_position] = req.load_value;
      end
    end else if (req.left_index > req.right_index) begin
      rsp.status = STAT_QUERY_BAD;
    end else begin
      lft     = 11'(req.left_index);
      nxt_end = 11'(req.right_index) + 11'd1;
      // An empty window restarts at the new left edge
      if (win_hi <= win_lo) begin
        win_lo = lft;
        win_hi = lft;
      end
      // Grow first, then shrink
      while (win_lo > lft) begin
        win_lo = win_lo - 11'd1;
        hist_add(win_lo);
      end
      while (win_hi < nxt_end) begin
        hist_add(win_hi);
        win_hi = win_hi + 11'd1;
      end
      while (win_hi > nxt_end) begin
        win_hi = win_hi - 11'd1;
        hist_drop(win_hi);
      end
      while (win_lo < lft) begin
        hist_drop(win_lo);
        win_lo = win_lo + 11'd1;
      end
    end
    rsp.pair_count = pair_sum[PAIR_W-1:0];
    return rsp;
  endfunction

  function automatic swepc_in_t noisy_item();
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    return noise[$bits(swepc_in_t)-1:0];
  endfunction

  function automatic swepc_in_t make_load(input int unsigned pos, input int unsigned val);
    swepc_in_t req;
    req = noisy_item();
    req.action        = ACT_LOAD;
    req.load_position = pos[POS_FIELD_W-1:0];
    req.load_value    = val[POS_FIELD_W-1:0];
    return req;
  endfunction

  function automatic swepc_in_t make_query(input int unsigned lft, input int unsigned rgt);
    swepc_in_t req;
    req = noisy_item();
    req.action      = ACT_QUERY;
    req.left_index  = lft[POS_FIELD_W-1:0];
    req.right_index = rgt[POS_FIELD_W-1:0];
    return req;
  endfunction

  // Hold one item until the block takes it, then record what it must return
  task automatic send_item(input swepc_in_t req);
    swepc_out_t rsp;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    rsp = model_pair_count(req);
    pending_counts.push_back(rsp);
    if (req.action == ACT_LOAD) begin
      n_loads++;
      if (rsp.status == STAT_LOAD_BUSY) n_load_refused++;
    end else begin
      n_queries++;
      if (rsp.status == STAT_QUERY_BAD) n_query_bad++;
    end
    if (rsp.pair_count > peak_pairs) peak_pairs = rsp.pair_count;
  endtask

  // Drop start for a random number of cycles, mostly short
  task automatic idle_gap();
    int unsigned n;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 40) n = 0;
    else if (roll < 85) n = $urandom_range(1, 3);
    else if (roll < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_with_gap(input swepc_in_t req);
    send_item(req);
    idle_gap();
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  // Queries with left above right, starting from the empty window
  task automatic test_flagged_queries();
    send_with_gap(make_query(5, 3));
    send_with_gap(make_query(NPOS - 1, 0));
    send_with_gap(make_query(1, 0));
    wait_drained();
  endtask

  // Restart, growth and shrink on both edges, and refused loads
  task automatic test_small_window();
    send_with_gap(make_load(4, NIDS - 1));
    send_with_gap(make_load(5, 0));
    send_with_gap(make_load(6, NIDS - 1));
    send_with_gap(make_load(7, NIDS - 1));
    send_with_gap(make_load(3, 0));
    send_with_gap(make_query(5, 7));
    send_with_gap(make_query(3, 6));
    send_with_gap(make_load(5, 7));
    send_with_gap(make_load(7, 0));
    send_with_gap(make_query(3, 7));
    send_with_gap(make_query(7, 7));
    send_with_gap(make_query(3, 3));
    send_with_gap(make_load(3, 9));
    send_with_gap(make_query(4, 4));
    wait_drained();
  endtask

  // Fill every position with one id, then span the whole store
  task automatic test_uniform_store();
    for (int p = 0; p < NPOS; p++) send_with_gap(make_load(p, NIDS - 1));
    send_with_gap(make_query(0, NPOS - 1));
    send_with_gap(make_query(NPOS - 1, NPOS - 1));
    send_with_gap(make_query(0, 0));
    wait_drained();
  endtask

  function automatic int unsigned pick_value();
    return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, NIDS - 1);
  endfunction

  // Mixed loads and queries, mostly small window moves
  task automatic test_random_mix();
    int          roll;
    int          lo;
    int          hi;
    int unsigned pos;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        roll = $urandom_range(0, 99);
        if (roll < 60 || win_hi <= win_lo) begin
          pos = $urandom_range(0, NPOS - 1);
        end else if (roll < 80) begin
          pos = win_lo + $urandom_range(0, win_hi - win_lo - 1);
        end else if (win_lo > 0) begin
          pos = win_lo - 1;
        end else if (win_hi < NPOS) begin
          pos = win_hi;
        end else begin
          pos = $urandom_range(0, NPOS - 1);
        end
        send_with_gap(make_load(pos, pick_value()));
      end else if (roll < 46) begin
        hi = $urandom_range(0, NPOS - 2);
        lo = $urandom_range(hi + 1, NPOS - 1);
        send_with_gap(make_query(lo, hi));
      end else if (roll < 50) begin
        lo = $urandom_range(0, NPOS - 1);
        hi = lo + $urandom_range(0, NPOS - 1 - lo);
        send_with_gap(make_query(lo, hi));
      end else begin
        lo = int'(win_lo) + $urandom_range(0, 16) - 8;
        if (lo < 0) lo = 0;
        if (lo > NPOS - 1) lo = NPOS - 1;
        hi = lo + $urandom_range(1, 48) - 1;
        if (hi > NPOS - 1) hi = NPOS - 1;
        send_with_gap(make_query(lo, hi));
      end
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic note_mismatch(input swepc_out_t want, input swepc_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on result %0d: expected pair_count %0d status %0d, got %0d status %0d",
               results_seen, want.pair_count, want.status, got.pair_count, got.status);
    end
  endtask

  // Compare each strobed result with the oldest pending one
  always @(posedge clk_i) begin : check_results
    swepc_out_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result %0d: pair_count %0d status %0d",
                   results_seen, result_o.pair_count, result_o.status);
        end
      end else begin
        want = pending_counts.pop_front();
        if (result_o.pair_count !== want.pair_count || result_o.status !== want.status) begin
          note_mismatch(want, result_o);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    no_idle        = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    cycle_count    = 0;
    n_loads        = 0;
    n_load_refused = 0;
    n_queries      = 0;
    n_query_bad    = 0;
    peak_pairs     = 0;
    clear_window_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_flagged_queries();
    test_small_window();
    test_uniform_store();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d loads (%0d refused inside the window) and %0d queries (%0d flagged).",
             n_loads, n_load_refused, n_queries, n_query_bad);
    $display("Checked %0d results, largest pair count %0d.", results_seen, peak_pairs);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_counts.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
